// File: hdl/fdac_pkg.sv
`default_nettype none

package fdac_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PULL_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PULL_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PULL_Z = 2'd2;

   localparam logic signed [CSR_DATA_BITS-1:0] PULL_X_RST = 16'sd0;
   localparam logic signed [CSR_DATA_BITS-1:0] PULL_Y_RST = 16'sd0;
   localparam logic signed [CSR_DATA_BITS-1:0] PULL_Z_RST = 16'sd16384;

   // Face classes
   localparam logic [1:0] CLASS_UNDERCUT = 2'd0;
   localparam logic [1:0] CLASS_NEAR     = 2'd1;
   localparam logic [1:0] CLASS_SAFE     = 2'd2;

   // Normalized normal: largest magnitude has its MSB at bit NORM_MSB
   localparam int NORM_BITS = 24;
   localparam int NORM_MSB  = NORM_BITS - 1;
   localparam int SQ1_BITS  = 2 * NORM_BITS;
   localparam int SQ_BITS   = 2 * NORM_BITS + 2;
   localparam int SQRT_STEPS = SQ_BITS / 2;
   localparam int LEN_BITS  = SQRT_STEPS;
   localparam int PP_BITS   = NORM_BITS + 1 + CSR_DATA_BITS;
   localparam int NUM_BITS  = PP_BITS + 2;
   localparam int NMAG_BITS = NUM_BITS - 1;
   localparam int NUM_SHIFT = 10;
   localparam int DVD_BITS  = NMAG_BITS + NUM_SHIFT;
   localparam int DOT_FRAC  = 24;
   localparam int Q_BITS    = DOT_FRAC + 1;
   localparam int DIV_STEPS = Q_BITS;

   // Angles in degrees, Q16
   localparam int ANG_BITS   = 23;
   localparam int ANG_S_BITS = ANG_BITS + 1;
   localparam logic [63:0] ANG_MAX_Q16 = 64'd90 << 16;
   localparam logic signed [ANG_S_BITS-1:0] ANG_UNDERCUT = -24'sd6554;   // below -0.1 deg
   localparam logic signed [ANG_S_BITS-1:0] ANG_NEAR     = 24'sd196608;  // 3 deg
   localparam logic [31:0] GREEN_SCALE = 32'd255;
   localparam logic [31:0] GREEN_HALF  = 32'd98304;
   localparam logic [15:0] RECIP_3     = 16'd43691;  // ceil(2^17 / 3)
   localparam int RAMP_BITS = 10;

   localparam logic [63:0] DEG2RAD_Q38 = 64'd4797524518;

   // Sine of a Q16 degree angle, Q30, eight-term series
   function automatic logic [63:0] sine_q30(input logic [63:0] deg_q16);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x    = (deg_q16 * DEG2RAD_Q38) >> 24;
      x2   = (x * x) >> 30;
      sum  = longint'(x);
      term = ((x * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   // Largest Q16 angle whose sine is at or below idx/(depth-1)
   function automatic logic [ANG_BITS-1:0] asin_entry(input int idx, input int depth);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] target;
      lo     = 64'd0;
      hi     = ANG_MAX_Q16;
      target = 64'(idx) << 30;
      for (int s = 0; s < 24; s++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (sine_q30(mid) * 64'(depth - 1) <= target) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      return lo[ANG_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/fdac_ifs.sv
`default_nettype none

// Triangle request channel
interface fdac_req_if #(parameter int COORD_BITS = 24);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] a_x;
   logic signed [COORD_BITS-1:0] a_y;
   logic signed [COORD_BITS-1:0] a_z;
   logic signed [COORD_BITS-1:0] b_x;
   logic signed [COORD_BITS-1:0] b_y;
   logic signed [COORD_BITS-1:0] b_z;
   logic signed [COORD_BITS-1:0] c_x;
   logic signed [COORD_BITS-1:0] c_y;
   logic signed [COORD_BITS-1:0] c_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   output ready);
endinterface

// Classification result channel
interface fdac_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] face_class;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, face_class, red, green, blue, input ready);
   modport sink   (input valid, face_class, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: hdl/face_draft_angle_classifier.sv
`default_nettype none

// Channel   Dir  Handshake           Payload
// req_if    in   valid/ready         a_x..c_z, COORD_BITS signed, 12 fraction bits
// rsp_if    out  valid/ready         face_class, red, green, blue
// csr_*     in   csr_we, no ready    csr_index, csr_wdata (pull vector, Q1.14)
//
// One triangle per cycle unless the output stalls; the path runs through 8 cross/normalize
// stages, the one-digit-per-stage square root (25 stages) and divider (25 stages).
// Synchronous reset clears the valid bits and loads the pull vector to +Z.
// A stalled output freezes the whole pipeline; req_if.ready is low only while
// a result waits at the output and rsp_if.ready is low.

module face_draft_angle_classifier #(
   parameter int COORD_BITS       = 24,
   parameter int ASIN_TABLE_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   fdac_req_if.sink   req_if,
   fdac_rsp_if.source rsp_if,
   input  logic                               csr_we,
   input  logic [fdac_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fdac_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import fdac_pkg::*;

   localparam int DIFF_SHIFT = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
   localparam int DIFF_BITS  = COORD_BITS + 1 - DIFF_SHIFT;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int N_BITS     = PROD_BITS + 1;
   localparam int PW         = $clog2(N_BITS);
   localparam int IDX_BITS   = $clog2(ASIN_TABLE_DEPTH);
   localparam int POS_BITS   = DOT_FRAC + IDX_BITS;
   localparam int SQ0_STAGE  = 8;
   localparam int TOTAL_STAGES = SQ0_STAGE + SQRT_STEPS + DIV_STEPS + 6;
   localparam logic [COORD_BITS:0] DIFF_BIAS =
      (COORD_BITS+1)'((64'd1 << DIFF_SHIFT) - 64'd1);
   localparam logic [IDX_BITS-1:0] TOP_IDX = IDX_BITS'(ASIN_TABLE_DEPTH - 1);
   localparam logic [Q_BITS-1:0]   DOT_ONE = Q_BITS'(1) << DOT_FRAC;

   logic adv;
   logic [TOTAL_STAGES-1:0] vld_ff;
   logic signed [CSR_DATA_BITS-1:0] pull_ff [3];

   // asin table, built at elaboration
   logic [ANG_BITS-1:0] asin_rom [ASIN_TABLE_DEPTH];
   for (genvar gi = 0; gi < ASIN_TABLE_DEPTH; gi++) begin : g_rom
      assign asin_rom[gi] = asin_entry(gi, ASIN_TABLE_DEPTH);
   end

   // Pipeline advances unless a result is held at the output
   assign adv          = ~vld_ff[TOTAL_STAGES-1] | rsp_if.ready;
   assign req_if.ready = adv;

   // Valid bits and pull registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         pull_ff[0] <= PULL_X_RST;
         pull_ff[1] <= PULL_Y_RST;
         pull_ff[2] <= PULL_Z_RST;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[TOTAL_STAGES-2:0], req_if.valid};
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PULL_X: pull_ff[0] <= csr_wdata;
               CSR_PULL_Y: pull_ff[1] <= csr_wdata;
               CSR_PULL_Z: pull_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Stage 0: edge vectors, scaled down toward zero for wide coordinates
   logic signed [COORD_BITS-1:0] va [3];
   logic signed [COORD_BITS-1:0] vb [3];
   logic signed [COORD_BITS-1:0] vc [3];
   logic signed [COORD_BITS:0]   de_full [3];
   logic signed [COORD_BITS:0]   df_full [3];
   logic signed [COORD_BITS:0]   de_sh [3];
   logic signed [COORD_BITS:0]   df_sh [3];
   logic signed [DIFF_BITS-1:0]  e_in [3];
   logic signed [DIFF_BITS-1:0]  f_in [3];
   logic signed [DIFF_BITS-1:0]  e_ff [3];
   logic signed [DIFF_BITS-1:0]  f_ff [3];

   assign va[0] = req_if.a_x;
   assign va[1] = req_if.a_y;
   assign va[2] = req_if.a_z;
   assign vb[0] = req_if.b_x;
   assign vb[1] = req_if.b_y;
   assign vb[2] = req_if.b_z;
   assign vc[0] = req_if.c_x;
   assign vc[1] = req_if.c_y;
   assign vc[2] = req_if.c_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         de_full[k] = (COORD_BITS+1)'(vb[k]) - (COORD_BITS+1)'(va[k]);
         df_full[k] = (COORD_BITS+1)'(vc[k]) - (COORD_BITS+1)'(va[k]);
         de_sh[k]   = (de_full[k] + (de_full[k][COORD_BITS] ? DIFF_BIAS : '0)) >>> DIFF_SHIFT;
         df_sh[k]   = (df_full[k] + (df_full[k][COORD_BITS] ? DIFF_BIAS : '0)) >>> DIFF_SHIFT;
         e_in[k]    = de_sh[k][DIFF_BITS-1:0];
         f_in[k]    = df_sh[k][DIFF_BITS-1:0];
      end
   end

   // Stage 1: cross product terms
   logic signed [PROD_BITS-1:0] pr_in [6];
   logic signed [PROD_BITS-1:0] pr_ff [6];
   always_comb begin
      pr_in[0] = PROD_BITS'(e_ff[1]) * PROD_BITS'(f_ff[2]);
      pr_in[1] = PROD_BITS'(e_ff[2]) * PROD_BITS'(f_ff[1]);
      pr_in[2] = PROD_BITS'(e_ff[2]) * PROD_BITS'(f_ff[0]);
      pr_in[3] = PROD_BITS'(e_ff[0]) * PROD_BITS'(f_ff[2]);
      pr_in[4] = PROD_BITS'(e_ff[0]) * PROD_BITS'(f_ff[1]);
      pr_in[5] = PROD_BITS'(e_ff[1]) * PROD_BITS'(f_ff[0]);
   end

   // Stage 2: normal components
   logic signed [N_BITS-1:0] n_in [3];
   logic signed [N_BITS-1:0] n_ff [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_in[k] = N_BITS'(pr_ff[2*k]) - N_BITS'(pr_ff[2*k+1]);
      end
   end

   // Stage 3: sign/magnitude and largest magnitude
   logic [N_BITS-1:0] mag3_in [3];
   logic [N_BITS-1:0] mag3_ff [3];
   logic              sgn3_ff [3];
   logic [N_BITS-1:0] mmax_in;
   logic [N_BITS-1:0] mmax_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag3_in[k] = n_ff[k][N_BITS-1] ? N_BITS'(-n_ff[k]) : N_BITS'(n_ff[k]);
      end
      mmax_in = mag3_in[0];
      if (mag3_in[1] > mmax_in) mmax_in = mag3_in[1];
      if (mag3_in[2] > mmax_in) mmax_in = mag3_in[2];
   end

   // Stage 4: leading one of the largest magnitude
   logic [PW-1:0]     lead_in;
   logic [PW-1:0]     lead_ff;
   logic              zero4_ff;
   logic [N_BITS-1:0] mag4_ff [3];
   logic              sgn4_ff [3];
   always_comb begin
      lead_in = '0;
      for (int i = 0; i < N_BITS; i++) begin
         if (mmax_ff[i]) lead_in = PW'(i);
      end
   end

   // Stage 5: power-of-two normalization (right shifts truncate toward zero)
   logic [N_BITS-1:0]    nsh [3];
   logic [NORM_BITS-1:0] nm_in [3];
   logic [NORM_BITS-1:0] nm_ff [3];
   logic                 sgn5_ff [3];
   logic                 zero5_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nsh[k] = (lead_ff >= PW'(NORM_MSB)) ? (mag4_ff[k] >> (lead_ff - PW'(NORM_MSB)))
                                             : (mag4_ff[k] << (PW'(NORM_MSB) - lead_ff));
         nm_in[k] = nsh[k][NORM_BITS-1:0];
      end
   end

   // Stage 6: squares and pull products
   logic [SQ1_BITS-1:0]        sq6_in [3];
   logic [SQ1_BITS-1:0]        sq6_ff [3];
   logic signed [NORM_BITS:0]  nv [3];
   logic signed [PP_BITS-1:0]  pp6_in [3];
   logic signed [PP_BITS-1:0]  pp6_ff [3];
   logic                       zero6_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq6_in[k] = SQ1_BITS'(nm_ff[k]) * SQ1_BITS'(nm_ff[k]);
         nv[k]     = sgn5_ff[k] ? -$signed({1'b0, nm_ff[k]}) : $signed({1'b0, nm_ff[k]});
         pp6_in[k] = PP_BITS'(nv[k]) * PP_BITS'(pull_ff[k]);
      end
   end

   // Stage 7: squared length and dot numerator
   logic [SQ_BITS-1:0]         sumsq_in;
   logic [SQ_BITS-1:0]         sumsq_ff;
   logic signed [NUM_BITS-1:0] num_in;
   logic signed [NUM_BITS-1:0] num_ff;
   logic                       zero7_ff;
   assign sumsq_in = SQ_BITS'(sq6_ff[0]) + SQ_BITS'(sq6_ff[1]) + SQ_BITS'(sq6_ff[2]);
   assign num_in   = NUM_BITS'(pp6_ff[0]) + NUM_BITS'(pp6_ff[1]) + NUM_BITS'(pp6_ff[2]);

   // Front stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            e_ff[k]    <= e_in[k];
            f_ff[k]    <= f_in[k];
            n_ff[k]    <= n_in[k];
            mag3_ff[k] <= mag3_in[k];
            sgn3_ff[k] <= n_ff[k][N_BITS-1];
            mag4_ff[k] <= mag3_ff[k];
            sgn4_ff[k] <= sgn3_ff[k];
            nm_ff[k]   <= nm_in[k];
            sgn5_ff[k] <= sgn4_ff[k];
            sq6_ff[k]  <= sq6_in[k];
            pp6_ff[k]  <= pp6_in[k];
         end
         for (int k = 0; k < 6; k++) begin
            pr_ff[k] <= pr_in[k];
         end
         mmax_ff  <= mmax_in;
         lead_ff  <= lead_in;
         zero4_ff <= (mmax_ff == '0);
         zero5_ff <= zero4_ff;
         zero6_ff <= zero5_ff;
         sumsq_ff <= sumsq_in;
         num_ff   <= num_in;
         zero7_ff <= zero6_ff;
      end
   end

   // Integer square root, one result bit per stage
   logic [SQ_BITS-1:0]   sq_v_ff   [SQRT_STEPS];
   logic [SQ_BITS-1:0]   sq_r_ff   [SQRT_STEPS];
   logic [NMAG_BITS-1:0] sq_num_ff [SQRT_STEPS];
   logic                 sq_neg_ff [SQRT_STEPS];
   logic                 sq_zero_ff[SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2 * (SQRT_STEPS - 1 - j));
      logic [SQ_BITS-1:0]   v_src;
      logic [SQ_BITS-1:0]   r_src;
      logic [SQ_BITS-1:0]   trial;
      logic [SQ_BITS-1:0]   sq_v_in;
      logic [SQ_BITS-1:0]   sq_r_in;
      logic [NMAG_BITS-1:0] num_src;
      logic                 neg_src;
      logic                 zero_src;
      if (j == 0) begin : g_first
         assign v_src    = sumsq_ff;
         assign r_src    = '0;
         assign neg_src  = num_ff[NUM_BITS-1];
         assign num_src  = num_ff[NUM_BITS-1] ? NMAG_BITS'(-num_ff) : NMAG_BITS'(num_ff);
         assign zero_src = zero7_ff;
      end else begin : g_next
         assign v_src    = sq_v_ff[j-1];
         assign r_src    = sq_r_ff[j-1];
         assign neg_src  = sq_neg_ff[j-1];
         assign num_src  = sq_num_ff[j-1];
         assign zero_src = sq_zero_ff[j-1];
      end
      always_comb begin
         trial = r_src + BIT;
         if (v_src >= trial) begin
            sq_v_in = v_src - trial;
            sq_r_in = (r_src >> 1) + BIT;
         end else begin
            sq_v_in = v_src;
            sq_r_in = r_src >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_v_ff[j]    <= sq_v_in;
            sq_r_ff[j]    <= sq_r_in;
            sq_num_ff[j]  <= num_src;
            sq_neg_ff[j]  <= neg_src;
            sq_zero_ff[j] <= zero_src;
         end
      end
   end

   // Restoring divider for the dot product, one quotient bit per stage
   logic [DVD_BITS-1:0] dv_rem_ff [DIV_STEPS];
   logic [Q_BITS-1:0]   dv_q_ff   [DIV_STEPS];
   logic [LEN_BITS-1:0] dv_len_ff [DIV_STEPS];
   logic                dv_ovf_ff [DIV_STEPS];
   logic                dv_neg_ff [DIV_STEPS];
   logic                dv_zero_ff[DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int K = Q_BITS - 1 - j;
      logic [DVD_BITS-1:0] rem_src;
      logic [Q_BITS-1:0]   q_src;
      logic [LEN_BITS-1:0] len_src;
      logic                ovf_src;
      logic                neg_src;
      logic                zero_src;
      logic [DVD_BITS-1:0] dsh;
      logic                ge;
      logic [DVD_BITS-1:0] dv_rem_in;
      logic [Q_BITS-1:0]   dv_q_in;
      if (j == 0) begin : g_first
         assign rem_src  = DVD_BITS'(sq_num_ff[SQRT_STEPS-1]) << NUM_SHIFT;
         assign q_src    = '0;
         assign len_src  = sq_r_ff[SQRT_STEPS-1][LEN_BITS-1:0];
         assign ovf_src  = rem_src >= (DVD_BITS'(len_src) << Q_BITS);
         assign neg_src  = sq_neg_ff[SQRT_STEPS-1];
         assign zero_src = sq_zero_ff[SQRT_STEPS-1];
      end else begin : g_next
         assign rem_src  = dv_rem_ff[j-1];
         assign q_src    = dv_q_ff[j-1];
         assign len_src  = dv_len_ff[j-1];
         assign ovf_src  = dv_ovf_ff[j-1];
         assign neg_src  = dv_neg_ff[j-1];
         assign zero_src = dv_zero_ff[j-1];
      end
      always_comb begin
         dsh       = DVD_BITS'(len_src) << K;
         ge        = (rem_src >= dsh);
         dv_rem_in = ge ? (rem_src - dsh) : rem_src;
         dv_q_in   = q_src | (Q_BITS'(ge) << K);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j]  <= dv_rem_in;
            dv_q_ff[j]    <= dv_q_in;
            dv_len_ff[j]  <= len_src;
            dv_ovf_ff[j]  <= ovf_src;
            dv_neg_ff[j]  <= neg_src;
            dv_zero_ff[j] <= zero_src;
         end
      end
   end

   // Clamp dot to 1.0 and scale to table position
   logic [Q_BITS-1:0]          dot_c;
   logic [Q_BITS+IDX_BITS-1:0] pos_full;
   logic [POS_BITS-1:0]        pos_ff;
   logic                       neg_p_ff;
   logic                       zero_p_ff;
   always_comb begin
      dot_c = (dv_ovf_ff[DIV_STEPS-1] || dv_q_ff[DIV_STEPS-1] > DOT_ONE)
              ? DOT_ONE : dv_q_ff[DIV_STEPS-1];
      pos_full = (Q_BITS+IDX_BITS)'(dot_c) * (Q_BITS+IDX_BITS)'(TOP_IDX);
   end

   // Table lookup of both neighbors
   logic [IDX_BITS-1:0]  idx;
   logic [IDX_BITS-1:0]  idx_hi;
   logic                 at_top;
   logic [ANG_BITS-1:0]  t0;
   logic [ANG_BITS-1:0]  t1;
   logic [ANG_BITS-1:0]  t0_ff;
   logic [ANG_BITS-1:0]  dt_ff;
   logic [DOT_FRAC-1:0]  frac_ff;
   logic                 neg_t_ff;
   logic                 zero_t_ff;
   always_comb begin
      idx    = pos_ff[POS_BITS-1:DOT_FRAC];
      at_top = (idx >= TOP_IDX);
      idx_hi = at_top ? idx : idx + IDX_BITS'(1);
      t0     = asin_rom[idx];
      t1     = asin_rom[idx_hi];
   end

   // Interpolation product
   logic [ANG_BITS+DOT_FRAC-1:0] ip_ff;
   logic [ANG_BITS-1:0]          t0_i_ff;
   logic                         neg_i_ff;
   logic                         zero_i_ff;

   // Signed angle
   logic [ANG_BITS-1:0]          amag;
   logic signed [ANG_S_BITS-1:0] ang_ff;
   assign amag = t0_i_ff + ip_ff[ANG_BITS+DOT_FRAC-1:DOT_FRAC];

   // Classification and green ramp numerator
   logic [31:0]          ramp_num;
   logic [RAMP_BITS-1:0] ramp_ff;
   logic [1:0]           cls_ff;
   assign ramp_num = 32'(ang_ff[ANG_BITS-1:0]) * GREEN_SCALE + GREEN_HALF;

   // Output stage: divide the ramp by three
   logic [RAMP_BITS+15:0] gmul;
   logic [1:0]            cls_out_ff;
   logic [7:0]            red_ff;
   logic [7:0]            green_ff;
   assign gmul = (RAMP_BITS+16)'(ramp_ff) * (RAMP_BITS+16)'(RECIP_3);

   // Back stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff    <= pos_full[POS_BITS-1:0];
         neg_p_ff  <= dv_neg_ff[DIV_STEPS-1];
         zero_p_ff <= dv_zero_ff[DIV_STEPS-1];

         t0_ff     <= t0;
         dt_ff     <= (!at_top && t1 > t0) ? t1 - t0 : '0;
         frac_ff   <= pos_ff[DOT_FRAC-1:0];
         neg_t_ff  <= neg_p_ff;
         zero_t_ff <= zero_p_ff;

         ip_ff     <= (ANG_BITS+DOT_FRAC)'(dt_ff) * (ANG_BITS+DOT_FRAC)'(frac_ff);
         t0_i_ff   <= t0_ff;
         neg_i_ff  <= neg_t_ff;
         zero_i_ff <= zero_t_ff;

         if (zero_i_ff) begin
            ang_ff <= '0;
         end else if (neg_i_ff) begin
            ang_ff <= -$signed({1'b0, amag});
         end else begin
            ang_ff <= $signed({1'b0, amag});
         end

         if (ang_ff <= ANG_UNDERCUT) begin
            cls_ff <= CLASS_UNDERCUT;
         end else if (ang_ff < ANG_NEAR) begin
            cls_ff <= CLASS_NEAR;
         end else begin
            cls_ff <= CLASS_SAFE;
         end
         ramp_ff <= (ang_ff > 0 && ang_ff < ANG_NEAR) ? ramp_num[16+RAMP_BITS-1:16] : '0;

         cls_out_ff <= cls_ff;
         case (cls_ff)
            CLASS_UNDERCUT: begin
               red_ff   <= 8'd255;
               green_ff <= 8'd0;
            end
            CLASS_NEAR: begin
               red_ff   <= 8'd255;
               green_ff <= gmul[24:17];
            end
            default: begin
               red_ff   <= 8'd0;
               green_ff <= 8'd255;
            end
         endcase
      end
   end

   assign rsp_if.valid      = vld_ff[TOTAL_STAGES-1];
   assign rsp_if.face_class = cls_out_ff;
   assign rsp_if.red        = red_ff;
   assign rsp_if.green      = green_ff;
   assign rsp_if.blue       = 8'd0;

endmodule

`default_nettype wire

// File: dv/fdac_draft_checker.sv
`default_nettype none

// Watches the request and result channels, predicts each classification
// and compares it with what the block returns.
module fdac_draft_checker (
   input  logic       clock,
   input  logic       reset,
   fdac_req_if        req_if,
   fdac_rsp_if        rsp_if,
   input  logic                               csr_we,
   input  logic [fdac_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fdac_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int         mismatches,
   output int         outstanding
);
   import fdac_pkg::*;

   localparam int LUT_DEPTH = 256;

   typedef struct packed {
      logic [1:0] face_class;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } face_color_type;

   longint unsigned  asin_lut [LUT_DEPTH];
   longint           pull_x, pull_y, pull_z;
   face_color_type   color_q [$];

   // Q30 sine of a Q16 degree angle, series to the 15th power
   function automatic longint unsigned sine_deg(longint unsigned deg);
      longint unsigned x, x2, term;
      longint          sum;
      x    = (deg * 64'd4797524518) >> 24;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      return (sum < 0) ? 64'd0 : longint'(sum);
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Signed Q16 draft angle of a face normal against the pull vector
   function automatic longint draft_deg(longint nx, longint ny, longint nz);
      longint unsigned m, len, d, pos, idx, frac, ang, t0, t1;
      longint          num;
      m = abs64(nx);
      if (abs64(ny) > m) m = abs64(ny);
      if (abs64(nz) > m) m = abs64(nz);
      if (m == 0) return 0;
      while (m >= (64'd1 << 24)) begin
         nx /= 2; ny /= 2; nz /= 2; m >>= 1;
      end
      while (m < (64'd1 << 23)) begin
         nx *= 2; ny *= 2; nz *= 2; m <<= 1;
      end
      len = root_floor(nx * nx + ny * ny + nz * nz);
      if (len == 0) return 0;
      num = nx * pull_x + ny * pull_y + nz * pull_z;
      d   = (abs64(num) << 10) / len;
      if (d > (64'd1 << 24)) d = 64'd1 << 24;
      pos  = d * (LUT_DEPTH - 1);
      idx  = pos >> 24;
      frac = pos & 64'hFF_FFFF;
      if (idx >= LUT_DEPTH - 1) begin
         ang = asin_lut[LUT_DEPTH - 1];
      end else begin
         t0  = asin_lut[idx];
         t1  = asin_lut[idx + 1];
         ang = t0;
         if (t1 > t0) ang += ((t1 - t0) * frac) >> 24;
      end
      return (num < 0) ? -longint'(ang) : longint'(ang);
   endfunction

   function automatic face_color_type classify_face();
      longint      ex, ey, ez, fx, fy, fz, ang;
      longint unsigned g;
      face_color_type c;
      ex  = longint'(req_if.b_x) - longint'(req_if.a_x);
      ey  = longint'(req_if.b_y) - longint'(req_if.a_y);
      ez  = longint'(req_if.b_z) - longint'(req_if.a_z);
      fx  = longint'(req_if.c_x) - longint'(req_if.a_x);
      fy  = longint'(req_if.c_y) - longint'(req_if.a_y);
      fz  = longint'(req_if.c_z) - longint'(req_if.a_z);
      ang = draft_deg(ey * fz - ez * fy, ez * fx - ex * fz, ex * fy - ey * fx);
      c.blue = 8'd0;
      if (ang * 10 < -65536) begin
         c.face_class = CLASS_UNDERCUT; c.red = 8'd255; c.green = 8'd0;
      end else if (ang < 3 * 65536) begin
         g = (ang <= 0) ? 0 : (longint'(ang) * 255 + 98304) / 196608;
         if (g > 255) g = 255;
         c.face_class = CLASS_NEAR; c.red = 8'd255; c.green = g[7:0];
      end else begin
         c.face_class = CLASS_SAFE; c.red = 8'd0; c.green = 8'd255;
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // asin table: largest angle whose sine stays at or below i/(depth-1)
   initial begin
      longint unsigned lo, hi, mid, target;
      mismatches  = 0;
      outstanding = 0;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         target = (longint'(i) << 30) / (LUT_DEPTH - 1);
         lo = 0;
         hi = 90 << 16;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (sine_deg(mid) <= target) lo = mid;
            else hi = mid - 1;
         end
         asin_lut[i] = lo;
      end
   end

   // pull vector copy, request prediction, result compare
   always @(posedge clock) begin
      face_color_type want;
      if (reset) begin
         pull_x = longint'(PULL_X_RST);
         pull_y = longint'(PULL_Y_RST);
         pull_z = longint'(PULL_Z_RST);
         color_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PULL_X: pull_x = longint'($signed(csr_wdata));
               CSR_PULL_Y: pull_y = longint'($signed(csr_wdata));
               CSR_PULL_Z: pull_z = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (color_q.size() == 0) begin
               report_mismatch("unexpected result, class", rsp_if.face_class, -1);
            end else begin
               want = color_q.pop_front();
               if (rsp_if.face_class !== want.face_class)
                  report_mismatch("face_class", rsp_if.face_class, want.face_class);
               if (rsp_if.red !== want.red) report_mismatch("red", rsp_if.red, want.red);
               if (rsp_if.green !== want.green)
                  report_mismatch("green", rsp_if.green, want.green);
               if (rsp_if.blue !== want.blue) report_mismatch("blue", rsp_if.blue, want.blue);
            end
         end
         if (req_if.valid && req_if.ready) color_q.push_back(classify_face());
      end
      outstanding = color_q.size();
   end

endmodule

`default_nettype wire

// File: dv/tb_face_draft_angle_classifier.sv
`default_nettype none

module tb_face_draft_angle_classifier;
   import fdac_pkg::*;

   localparam int CMIN = -8388608;
   localparam int CMAX = 8388607;

   typedef struct {
      int v [9];   // a_x a_y a_z b_x b_y b_z c_x c_y c_z
   } face_tri_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int   mismatches, outstanding;
   bit   quiet = 0;       // no idling near the end
   bit   hold_long = 0;   // receiver long hold-off request
   int   px = 0, py = 0, pz = 16384;

   fdac_req_if #(.COORD_BITS(24)) req_if ();
   fdac_rsp_if rsp_if ();

   face_draft_angle_classifier #(.COORD_BITS(24), .ASIN_TABLE_DEPTH(256)) dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   fdac_draft_checker chk (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb_face_draft_angle_classifier: done, errors");
      $finish;
   end

   function automatic int rnd_coord(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic face_tri_type make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                             int c0, int c1, int c2);
      face_tri_type t;
      t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
      return t;
   endfunction

   // Random triangle; half are shaped to land near the vertical band
   function automatic face_tri_type random_tri();
      face_tri_type t;
      int s, n;
      case ($urandom_range(0, 5))
         0: for (int i = 0; i < 9; i++) t.v[i] = int'($signed(24'($urandom())));
         1: for (int i = 0; i < 9; i++) t.v[i] = rnd_coord(4096);
         2: begin
            for (int i = 0; i < 6; i++) t.v[i] = rnd_coord(1 << 22);
            n = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++)
               t.v[6 + i] = t.v[i] + (t.v[3 + i] - t.v[i]) / 2 + rnd_coord(n);
         end
         default: begin
            // face containing the pull direction, plus a tilt
            s = $urandom_range(1, 127);
            n = 1 << $urandom_range(0, 16);
            for (int i = 0; i < 3; i++) t.v[i] = rnd_coord(1 << 22);
            t.v[3] = t.v[0] + px * s + rnd_coord(n);
            t.v[4] = t.v[1] + py * s + rnd_coord(n);
            t.v[5] = t.v[2] + pz * s + rnd_coord(n);
            for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[i] + rnd_coord(1 << 20);
         end
      endcase
      return t;
   endfunction

   task automatic send_tri(face_tri_type t);
      req_if.valid <= 1'b1;
      req_if.a_x <= 24'(t.v[0]); req_if.a_y <= 24'(t.v[1]); req_if.a_z <= 24'(t.v[2]);
      req_if.b_x <= 24'(t.v[3]); req_if.b_y <= 24'(t.v[4]); req_if.b_z <= 24'(t.v[5]);
      req_if.c_x <= 24'(t.v[6]); req_if.c_y <= 24'(t.v[7]); req_if.c_z <= 24'(t.v[8]);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_pull(int x, int y, int z);
      px = x; py = y; pz = z;
      csr_we <= 1'b1; csr_index <= CSR_PULL_X; csr_wdata <= x[15:0];
      @(posedge clock);
      csr_index <= CSR_PULL_Y; csr_wdata <= y[15:0];
      @(posedge clock);
      csr_index <= CSR_PULL_Z; csr_wdata <= z[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_long = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.a_x <= '0; req_if.a_y <= '0; req_if.a_z <= '0;
      req_if.b_x <= '0; req_if.b_y <= '0; req_if.b_z <= '0;
      req_if.c_x <= '0; req_if.c_y <= '0; req_if.c_z <= '0;
      csr_we <= 1'b0; csr_index <= CSR_PULL_X; csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed faces under the reset pull (+Z)
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));          // faces +Z
      send_tri(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));          // faces -Z
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 0, 4096));          // vertical wall
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 100));        // slight tilt
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, -7));         // slight tilt the other way
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 4096 * 19));  // about 3 degrees
      send_tri(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));                // zero area
      send_tri(make_tri(0, 0, 0, 100, 200, 300, 200, 400, 600));    // collinear
      send_tri(make_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
      send_tri(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
      send_tri(make_tri(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0));
      send_tri(make_tri(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX));
      send_tri(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
      send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));                // smallest face
      drain();

      // pull extremes, zero and a non-unit vector
      write_pull(16384, 0, 0);
      send_tri(make_tri(0, 0, 0, 0, 4096, 0, 0, 0, 4096));
      send_tri(make_tri(0, 0, 0, 0, 0, 4096, 0, 4096, 0));
      drain();
      write_pull(-16384, -16384, -16384);
      send_tri(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
      send_tri(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
      drain();
      write_pull(0, 0, 0);
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
      drain();

      // random phases, each under its own pull setting
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_pull(0, 0, 16384);
            1: write_pull(0, -16384, 0);
            2: write_pull(11585, 0, -11585);
            3: write_pull(9459, 9459, 9459);
            4: write_pull(rnd_coord(16384), rnd_coord(16384), rnd_coord(16384));
            default: write_pull(0, 16384, 0);
         endcase
         if (ph == 5) quiet = 1;
         for (int i = 0; i < 100; i++) begin
            if (ph == 1 && i == 20) hold_long = 1;
            send_tri(random_tri());
         end
         if (ph == 2) begin
            // sender waits for every result before going on
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            for (int i = 0; i < 5; i++) send_tri(random_tri());
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("tb_face_draft_angle_classifier: done, clean");
      else
         $display("tb_face_draft_angle_classifier: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
